/* rtl/core/okt_pkg.sv */
package okt_pkg;

    localparam int DEPTH       = 16;
    localparam int PRIO_LEVELS = 3;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FUNC_W = 3;
    localparam int KEY_W  = 16;
    localparam int PRI_W  = 2;
    localparam int PAY_W  = 32;
    localparam int STAT_W = 3;

    localparam logic [FUNC_W-1:0] F_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] F_REM_KEY  = 3'd1;
    localparam logic [FUNC_W-1:0] F_REM_PRIO = 3'd2;
    localparam logic [FUNC_W-1:0] F_LIST     = 3'd3;
    localparam logic [FUNC_W-1:0] F_SEARCH   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic [PRI_W-1:0]  priority_req;
        logic [PAY_W-1:0]  payload;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  out_key;
        logic [PRI_W-1:0]  out_priority;
        logic [PAY_W-1:0]  out_payload;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PRI_W-1:0] prio;
        logic [PAY_W-1:0] payload;
    } entry_t;

    // Per-cycle control of the cell ring
    typedef struct packed {
        logic             rotate;
        logic             shift;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_entry;
    } chain_ctrl_t;

    function automatic logic [PRI_W-1:0] clamp_prio(input logic [PRI_W-1:0] p);
        logic [PRI_W-1:0] r;
        r = p;
        if (p == '0) begin
            r = PRI_W'(1);
        end else if (p > PRI_W'(PRIO_LEVELS)) begin
            r = PRI_W'(PRIO_LEVELS);
        end
        return r;
    endfunction

endpackage

/* rtl/core/okt_cell.sv */
module okt_cell (
    input  logic                  aclk,
    input  logic                  take_next,
    input  logic                  wr_en,
    input  okt_pkg::entry_t       nb_entry,
    input  okt_pkg::entry_t       wr_entry,
    input  logic [okt_pkg::KEY_W-1:0] q_key,
    input  logic [okt_pkg::PRI_W-1:0] q_prio,
    output okt_pkg::entry_t       entry,
    output logic                  key_hit,
    output logic                  prio_hit
);
    import okt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (take_next) begin
            entry_next = nb_entry;
        end else if (wr_en) begin
            entry_next = wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign key_hit  = (entry_reg.key == q_key);
    assign prio_hit = (entry_reg.prio == q_prio);

endmodule

/* rtl/core/okt_chain.sv */
module okt_chain (
    input  logic                          aclk,
    input  okt_pkg::chain_ctrl_t          ctrl,
    input  logic [okt_pkg::DEPTH-1:0]     first,
    input  logic [okt_pkg::CNT_W-1:0]     count,
    input  logic [okt_pkg::KEY_W-1:0]     q_key,
    input  logic [okt_pkg::PRI_W-1:0]     q_prio,
    output logic [okt_pkg::DEPTH-1:0]     key_hit,
    output logic [okt_pkg::DEPTH-1:0]     prio_hit,
    output okt_pkg::entry_t               head,
    output okt_pkg::entry_t               sel
);
    import okt_pkg::*;

    entry_t             ent [DEPTH];
    logic [DEPTH-1:0]   raw_key_hit;
    logic [DEPTH-1:0]   raw_prio_hit;
    logic [DEPTH:0]     seen;

    assign seen[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            localparam int NB = (i + 1) % DEPTH;
            logic at_or_after;
            logic valid;

            // cells at and behind the removed one pull from their neighbor
            assign seen[i+1]   = seen[i] | first[i];
            assign at_or_after = seen[i+1];
            assign valid       = (count > CNT_W'(i));

            okt_cell u_cell (
                .aclk      (aclk),
                .take_next (ctrl.rotate | (ctrl.shift & at_or_after)),
                .wr_en     (ctrl.wr_en && (ctrl.wr_idx == IDX_W'(i))),
                .nb_entry  (ent[NB]),
                .wr_entry  (ctrl.wr_entry),
                .q_key     (q_key),
                .q_prio    (q_prio),
                .entry     (ent[i]),
                .key_hit   (raw_key_hit[i]),
                .prio_hit  (raw_prio_hit[i])
            );

            assign key_hit[i]  = raw_key_hit[i] & valid;
            assign prio_hit[i] = raw_prio_hit[i] & valid;
        end
    endgenerate

    always_comb begin
        sel = '0;
        for (int k = 0; k < DEPTH; k++) begin
            sel = sel | (ent[k] & {$bits(entry_t){first[k]}});
        end
    end

    assign head = ent[0];

endmodule

/* rtl/core/ordered_keyed_task_table.sv */
// Insertion-ordered table of up to DEPTH entries (unique 16-bit key, priority
// 1..PRIO_LEVELS, 32-bit payload) kept in a ring of cells. Insert, remove by
// key, remove by priority and search each pass through accept, parallel
// match over all cells and execute, in that order, plus any wait on
// m_ready; removal closes the gap by shifting the cells behind the match one
// step in that execute cycle. List uses the same accept, match and execute
// steps and then walks the ring once per priority level, one cell per cycle
// through the head cell while the ring is not held for m_ready, and ends
// early after the level that holds the last entry; it emits one result per
// entry, last set on the final one. No new transaction is accepted until the
// current one has placed its final result in the output register.
module ordered_keyed_task_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  okt_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output okt_pkg::out_item_t  m_item
);
    import okt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_LIST  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [PRI_W-1:0] lvl_reg, lvl_next;
    logic [DEPTH-1:0] hit_reg, hit_next;
    in_item_t         op_reg, op_next;
    logic             m_valid_reg;
    out_item_t        m_item_reg;

    chain_ctrl_t      ctrl;
    logic [DEPTH-1:0] first;
    logic [DEPTH-1:0] key_hit;
    logic [DEPTH-1:0] prio_hit;
    entry_t           head;
    entry_t           sel;
    logic             out_free;
    logic             ld;
    out_item_t        res;
    logic             head_match;

    // lowest set bit: first match in insertion order
    assign first = hit_reg & (~hit_reg + DEPTH'(1));

    okt_chain u_chain (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .first    (first),
        .count    (count_reg),
        .q_key    (op_reg.key),
        .q_prio   (op_reg.priority_req),
        .key_hit  (key_hit),
        .prio_hit (prio_hit),
        .head     (head),
        .sel      (sel)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == S_IDLE);
    assign head_match = ({1'b0, pos_reg} < count_reg) && (head.prio == lvl_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        emitted_next = emitted_reg;
        pos_next     = pos_reg;
        lvl_next     = lvl_reg;
        hit_next     = hit_reg;
        op_next      = op_reg;
        ctrl         = '0;
        ld           = 1'b0;
        res          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_item;
                    state_next = S_MATCH;
                end
            end
            S_MATCH: begin
                hit_next   = (op_reg.func == F_REM_PRIO) ? prio_hit : key_hit;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    res.last   = 1'b1;
                    case (op_reg.func)
                        F_INSERT: begin
                            ld = 1'b1;
                            if (|hit_reg) begin
                                res.status = ST_DUP;
                            end else if (count_reg == CNT_W'(DEPTH)) begin
                                res.status = ST_FULL;
                            end else begin
                                res.status            = ST_OK;
                                res.out_key           = op_reg.key;
                                res.out_priority      = clamp_prio(op_reg.priority_req);
                                res.out_payload       = op_reg.payload;
                                ctrl.wr_en            = 1'b1;
                                ctrl.wr_idx           = count_reg[IDX_W-1:0];
                                ctrl.wr_entry.key     = op_reg.key;
                                ctrl.wr_entry.prio    = clamp_prio(op_reg.priority_req);
                                ctrl.wr_entry.payload = op_reg.payload;
                                count_next            = count_reg + CNT_W'(1);
                            end
                        end
                        F_REM_KEY, F_REM_PRIO, F_SEARCH: begin
                            ld = 1'b1;
                            if (count_reg == '0) begin
                                res.status = ST_EMPTY;
                            end else if (!(|hit_reg)) begin
                                res.status = ST_NOTFOUND;
                            end else begin
                                res.status       = ST_OK;
                                res.out_key      = sel.key;
                                res.out_priority = sel.prio;
                                res.out_payload  = sel.payload;
                                if (op_reg.func != F_SEARCH) begin
                                    ctrl.shift = 1'b1;
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        F_LIST: begin
                            if (count_reg == '0) begin
                                ld         = 1'b1;
                                res.status = ST_EMPTY;
                            end else begin
                                state_next   = S_LIST;
                                pos_next     = '0;
                                lvl_next     = PRI_W'(1);
                                emitted_next = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LIST: begin
                // hold the ring while a matching head waits for the output
                if (!(head_match && !out_free)) begin
                    ctrl.rotate = 1'b1;
                    pos_next    = pos_reg + IDX_W'(1);
                    if (head_match) begin
                        ld               = 1'b1;
                        res.status       = ST_OK;
                        res.out_key      = head.key;
                        res.out_priority = head.prio;
                        res.out_payload  = head.payload;
                        res.last         = ((emitted_reg + CNT_W'(1)) == count_reg);
                        emitted_next     = emitted_reg + CNT_W'(1);
                    end
                    if (pos_reg == IDX_W'(DEPTH - 1)) begin
                        lvl_next = lvl_reg + PRI_W'(1);
                        if ((lvl_reg == PRI_W'(PRIO_LEVELS)) || (emitted_next == count_reg)) begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        emitted_reg <= emitted_next;
        pos_reg     <= pos_next;
        lvl_reg     <= lvl_next;
        hit_reg     <= hit_next;
        op_reg      <= op_next;
        if (ld) begin
            m_item_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_unique_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && op_reg.func != F_REM_PRIO) |-> $onehot0(hit_reg))
        else $error("more than one cell holds the same key");

    a_nonlast_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.last) |-> (state_reg == S_LIST))
        else $error("non-final result outside a list transaction");

    a_ring_restored: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(state_reg == S_LIST) |-> (pos_reg == '0))
        else $error("list ended with the ring out of order");

    a_list_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |-> (emitted_reg <= count_reg))
        else $error("list emitted more results than entries");

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import okt_pkg::*;

    localparam int N_RANDOM     = 96;
    localparam int MAX_GAP      = 18;
    localparam int POOL_SIZE    = 32;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;

    // func codes the block ignores
    localparam logic [FUNC_W-1:0] F_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] F_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] F_RSVD7 = 3'd7;

    typedef struct {
        in_item_t  cmd;
        bit        typed;
        out_item_t reply;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // shadow copy of the table
    entry_t    shadow_entries [DEPTH];
    int        shadow_count;
    out_item_t cmd_replies[$];
    out_item_t pending_replies[$];

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bit filling;
    bit s_no_idle;
    bit m_no_idle;
    int err_count;
    int cycle_cnt;

    ordered_keyed_task_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #1 aclk = ~aclk;

    function automatic in_item_t mk_cmd(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                                        input logic [PRI_W-1:0] p, input logic [PAY_W-1:0] d);
        in_item_t c;
        c.func         = f;
        c.key          = k;
        c.priority_req = p;
        c.payload      = d;
        return c;
    endfunction

    function automatic out_item_t mk_reply(input logic [STAT_W-1:0] st,
                                           input logic [KEY_W-1:0] k,
                                           input logic [PRI_W-1:0] p,
                                           input logic [PAY_W-1:0] d, input logic lst);
        out_item_t r;
        r.status       = st;
        r.out_key      = k;
        r.out_priority = p;
        r.out_payload  = d;
        r.last         = lst;
        return r;
    endfunction

    function automatic out_item_t entry_reply(input int idx, input logic lst);
        return mk_reply(ST_OK, shadow_entries[idx].key, shadow_entries[idx].prio,
                        shadow_entries[idx].payload, lst);
    endfunction

    function automatic dir_row_t mk_row(input in_item_t c, input bit typed, input out_item_t r);
        dir_row_t row;
        row.cmd   = c;
        row.typed = typed;
        row.reply = r;
        return row;
    endfunction

    function automatic int find_key(input logic [KEY_W-1:0] k);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_entries[i].key == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int draw_gap(input bit no_idle);
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic string fmt_reply(input out_item_t r);
        return $sformatf("st=%0d key=%h pri=%0d pay=%h last=%b",
                         r.status, r.out_key, r.out_priority, r.out_payload, r.last);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t ERROR: %s", $time, msg);
        end
    endtask

    // Apply one command to the shadow table; results land in cmd_replies.
    task automatic apply_cmd_to_shadow(input in_item_t c);
        int hit;
        logic [PRI_W-1:0] p;
        cmd_replies.delete();
        hit = -1;
        case (c.func)
            F_INSERT: begin
                if (find_key(c.key) >= 0) begin
                    cmd_replies.push_back(mk_reply(ST_DUP, '0, '0, '0, 1'b1));
                end else if (shadow_count >= DEPTH) begin
                    cmd_replies.push_back(mk_reply(ST_FULL, '0, '0, '0, 1'b1));
                end else begin
                    p = c.priority_req;
                    if (p == '0) begin
                        p = PRI_W'(1);
                    end else if (p > PRI_W'(PRIO_LEVELS)) begin
                        p = PRI_W'(PRIO_LEVELS);
                    end
                    shadow_entries[shadow_count].key     = c.key;
                    shadow_entries[shadow_count].prio    = p;
                    shadow_entries[shadow_count].payload = c.payload;
                    shadow_count++;
                    cmd_replies.push_back(entry_reply(shadow_count - 1, 1'b1));
                end
            end
            F_REM_KEY, F_REM_PRIO: begin
                if (shadow_count == 0) begin
                    cmd_replies.push_back(mk_reply(ST_EMPTY, '0, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        if (hit < 0 && (c.func == F_REM_KEY ? shadow_entries[i].key == c.key
                                                            : shadow_entries[i].prio ==
                                                              c.priority_req)) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        cmd_replies.push_back(mk_reply(ST_NOTFOUND, '0, '0, '0, 1'b1));
                    end else begin
                        cmd_replies.push_back(entry_reply(hit, 1'b1));
                        for (int i = hit; i < shadow_count - 1; i++) begin
                            shadow_entries[i] = shadow_entries[i + 1];
                        end
                        shadow_count--;
                    end
                end
            end
            F_LIST: begin
                if (shadow_count == 0) begin
                    cmd_replies.push_back(mk_reply(ST_EMPTY, '0, '0, '0, 1'b1));
                end else begin
                    for (int lvl = 1; lvl <= PRIO_LEVELS; lvl++) begin
                        for (int i = 0; i < shadow_count; i++) begin
                            if (shadow_entries[i].prio == PRI_W'(lvl)) begin
                                cmd_replies.push_back(entry_reply(i, 1'b0));
                            end
                        end
                    end
                    cmd_replies[cmd_replies.size() - 1].last = 1'b1;
                end
            end
            F_SEARCH: begin
                if (shadow_count == 0) begin
                    cmd_replies.push_back(mk_reply(ST_EMPTY, '0, '0, '0, 1'b1));
                end else begin
                    hit = find_key(c.key);
                    if (hit < 0) begin
                        cmd_replies.push_back(mk_reply(ST_NOTFOUND, '0, '0, '0, 1'b1));
                    end else begin
                        cmd_replies.push_back(entry_reply(hit, 1'b1));
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    function automatic in_item_t build_random_cmd();
        int roll;
        logic [FUNC_W-1:0] f;
        logic [KEY_W-1:0]  k;
        logic [PRI_W-1:0]  p;
        // alternate between filling toward full and draining toward empty
        if (filling && shadow_count == DEPTH && $urandom_range(0, 3) == 0) begin
            filling = 1'b0;
        end else if (!filling && shadow_count == 0 && $urandom_range(0, 2) == 0) begin
            filling = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            f = FUNC_W'($urandom_range(F_RSVD5, F_RSVD7));
        end else if (filling) begin
            f = roll < 65 ? F_INSERT : roll < 75 ? F_REM_KEY : roll < 85 ? F_REM_PRIO :
                roll < 93 ? F_SEARCH : F_LIST;
        end else begin
            f = roll < 20 ? F_INSERT : roll < 48 ? F_REM_KEY : roll < 76 ? F_REM_PRIO :
                roll < 90 ? F_SEARCH : F_LIST;
        end
        // keys mostly live or from a small pool so hits and duplicates are common
        roll = $urandom_range(0, 99);
        if (shadow_count > 0 && roll < (f == F_INSERT ? 20 : 65)) begin
            k = shadow_entries[$urandom_range(0, shadow_count - 1)].key;
        end else if (roll < 90) begin
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            k = KEY_W'($urandom);
        end
        if (f == F_REM_PRIO && $urandom_range(0, 9) != 0) begin
            p = PRI_W'($urandom_range(1, PRIO_LEVELS));
        end else begin
            p = PRI_W'($urandom_range(0, 3));
        end
        return mk_cmd(f, k, p, PAY_W'($urandom));
    endfunction

    task automatic send_cmd(input in_item_t c, input bit typed, input out_item_t reply);
        int gap;
        if ($urandom_range(0, 15) == 0) begin
            s_no_idle = ~s_no_idle;
        end
        gap = draw_gap(s_no_idle);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // transaction accepted at this edge
        apply_cmd_to_shadow(c);
        if (typed) begin
            pending_replies.push_back(reply);
        end else begin
            foreach (cmd_replies[i]) begin
                pending_replies.push_back(cmd_replies[i]);
            end
        end
    endtask

    task automatic check_reply(input out_item_t got);
        out_item_t want;
        if (pending_replies.size() == 0) begin
            flag_error($sformatf("result with nothing pending: %s", fmt_reply(got)));
            return;
        end
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.out_key !== want.out_key ||
            got.out_priority !== want.out_priority || got.out_payload !== want.out_payload ||
            got.last !== want.last) begin
            flag_error($sformatf("mismatch: expected %s, got %s",
                                 fmt_reply(want), fmt_reply(got)));
        end
    endtask

    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                m_no_idle = ~m_no_idle;
            end
            gap = draw_gap(m_no_idle);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            check_reply(m_item);
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        dir_row_t rows[$];
        in_item_t cmd;
        int n_done;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        shadow_count = 0;
        err_count    = 0;
        filling      = 1'b1;
        s_no_idle    = 1'b0;
        m_no_idle    = 1'b0;
        key_pool[0]  = '0;
        key_pool[1]  = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = KEY_W'($urandom);
        end

        // empty table on list, search and both removes
        rows.push_back(mk_row(mk_cmd(F_LIST, 16'h0000, 2'd0, 32'h0), 1'b1,
                              mk_reply(ST_EMPTY, '0, '0, '0, 1'b1)));
        rows.push_back(mk_row(mk_cmd(F_SEARCH, 16'h0005, 2'd1, 32'h0), 1'b1,
                              mk_reply(ST_EMPTY, '0, '0, '0, 1'b1)));
        rows.push_back(mk_row(mk_cmd(F_REM_KEY, 16'h0005, 2'd1, 32'h0), 1'b1,
                              mk_reply(ST_EMPTY, '0, '0, '0, 1'b1)));
        rows.push_back(mk_row(mk_cmd(F_REM_PRIO, 16'h0000, 2'd1, 32'h0), 1'b1,
                              mk_reply(ST_EMPTY, '0, '0, '0, 1'b1)));
        // priority 0 is stored as 1
        rows.push_back(mk_row(mk_cmd(F_INSERT, 16'h0000, 2'd0, 32'h0), 1'b1,
                              mk_reply(ST_OK, 16'h0000, 2'd1, 32'h0, 1'b1)));
        rows.push_back(mk_row(mk_cmd(F_INSERT, 16'hffff, 2'd3, 32'hffffffff), 1'b1,
                              mk_reply(ST_OK, 16'hffff, 2'd3, 32'hffffffff, 1'b1)));
        rows.push_back(mk_row(mk_cmd(F_INSERT, 16'h0000, 2'd2, 32'h1234), 1'b1,
                              mk_reply(ST_DUP, '0, '0, '0, 1'b1)));
        rows.push_back(mk_row(mk_cmd(F_INSERT, 16'h1234, 2'd2, 32'ha5a5a5a5), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_INSERT, 16'h0077, 2'd1, 32'h5a5a5a5a), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_SEARCH, 16'hffff, 2'd0, 32'h0), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_SEARCH, 16'h9999, 2'd0, 32'h0), 1'b1,
                              mk_reply(ST_NOTFOUND, '0, '0, '0, 1'b1)));
        rows.push_back(mk_row(mk_cmd(F_REM_KEY, 16'h9999, 2'd0, 32'h0), 1'b1,
                              mk_reply(ST_NOTFOUND, '0, '0, '0, 1'b1)));
        // out-of-range priority never matches on remove
        rows.push_back(mk_row(mk_cmd(F_REM_PRIO, 16'h0000, 2'd0, 32'h0), 1'b1,
                              mk_reply(ST_NOTFOUND, '0, '0, '0, 1'b1)));
        rows.push_back(mk_row(mk_cmd(F_LIST, 16'h0000, 2'd0, 32'h0), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_RSVD5, 16'h0000, 2'd1, 32'h0), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_RSVD6, 16'h1234, 2'd2, 32'h1), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_RSVD7, 16'hffff, 2'd3, 32'hffffffff), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_REM_PRIO, 16'h0000, 2'd1, 32'h0), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_REM_PRIO, 16'h0000, 2'd2, 32'h0), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_REM_PRIO, 16'h0000, 2'd2, 32'h0), 1'b1,
                              mk_reply(ST_NOTFOUND, '0, '0, '0, 1'b1)));
        rows.push_back(mk_row(mk_cmd(F_REM_KEY, 16'hffff, 2'd0, 32'h0), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_LIST, 16'h0000, 2'd0, 32'h0), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_REM_KEY, 16'h0077, 2'd0, 32'h0), 1'b0, '0));
        rows.push_back(mk_row(mk_cmd(F_LIST, 16'h0000, 2'd0, 32'h0), 1'b1,
                              mk_reply(ST_EMPTY, '0, '0, '0, 1'b1)));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            send_cmd(rows[i].cmd, rows[i].typed, rows[i].reply);
        end

        n_done = 0;
        while (n_done < N_RANDOM) begin
            cmd = build_random_cmd();
            send_cmd(cmd, 1'b0, '0);
            if (cmd.func <= F_SEARCH) begin
                n_done++;
            end
        end
        s_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_replies.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_replies.size()));
        end

        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
